/* src/utf8d_pkg.sv */
// Shared constants and types for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 3;
    localparam int LEN_W  = 3;
    localparam int HELD_W = 2;

    localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2 = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3 = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4 = 21'h010000;

    localparam logic [LEN_W-1:0] LEN_IDLE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        logic            rep;
        logic            eot;
        logic            start;
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0] part;
    } t_fresh;

endpackage

/* src/utf8d_if.sv */
// Handshake channels for raw bytes and decoded code points.
interface utf8d_byte_if;
    logic                           valid;
    logic                           ready;
    logic [utf8d_pkg::BYTE_W-1:0]   byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface utf8d_cp_if;
    logic                           valid;
    logic                           ready;
    logic [utf8d_pkg::CP_W-1:0]     code_point;
    logic                           replaced;
    logic                           end_of_text;
    logic                           last;

    modport source (output valid, output code_point, output replaced,
                    output end_of_text, output last, input ready);
    modport sink   (input valid, input code_point, input replaced,
                    input end_of_text, input last, output ready);
endinterface

/* src/utf8_stream_decoder.sv */
// UTF-8 stream decoder: one byte per item in, code points with U+FFFD out.
// The first result of a byte is registered and shows in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and the output is
// ready; a byte that gives n results (up to 4) stalls the input while
// the result register drains them.
// Reset: synchronous, active low; no sequence pending, no result held.
module utf8_stream_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8d_byte_if.sink           i_byte,
    utf8d_cp_if.source           o_cp
);

    logic [utf8d_pkg::LEN_W-1:0]  r_seq_len, n_seq_len;
    logic [utf8d_pkg::HELD_W-1:0] r_held, n_held;
    logic [utf8d_pkg::CP_W-1:0]   r_partial, n_partial;

    logic [utf8d_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [utf8d_pkg::CP_W-1:0]   r_cp, n_cp;
    logic                         r_rep, n_rep;
    logic                         r_eot, n_eot;

    logic [utf8d_pkg::BYTE_W-1:0] byte_in;
    logic                         in_fire;
    logic                         out_fire;
    logic                         is_cont;
    logic [utf8d_pkg::CP_W-1:0]   cp_cat;
    logic [utf8d_pkg::LEN_W-1:0]  held_inc;
    logic                         seq_done;
    logic                         seq_bad;
    logic [utf8d_pkg::HELD_W-1:0] held_cap;
    logic [utf8d_pkg::CNT_W-1:0]  base_cnt;
    utf8d_pkg::t_fresh            fresh;

    function automatic utf8d_pkg::t_fresh decode_fresh(
        input logic [utf8d_pkg::BYTE_W-1:0] b
    );
        utf8d_pkg::t_fresh f;
        f = '0;
        case (b) inside
            8'h00: begin
                f.emit = 1'b1;
                f.eot  = 1'b1;
            end
            [8'h01:8'h7F]: begin
                f.emit = 1'b1;
                f.cp   = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, b};
            end
            [8'hC0:8'hDF]: begin
                f.start = 1'b1;
                f.len   = utf8d_pkg::LEN_TWO;
                f.part  = {{(utf8d_pkg::CP_W-5){1'b0}}, b[4:0]};
            end
            [8'hE0:8'hEF]: begin
                f.start = 1'b1;
                f.len   = utf8d_pkg::LEN_THREE;
                f.part  = {{(utf8d_pkg::CP_W-4){1'b0}}, b[3:0]};
            end
            [8'hF0:8'hF7]: begin
                f.start = 1'b1;
                f.len   = utf8d_pkg::LEN_FOUR;
                f.part  = {{(utf8d_pkg::CP_W-3){1'b0}}, b[2:0]};
            end
            default: begin
                f.emit = 1'b1;
                f.cp   = utf8d_pkg::REPL_CP;
                f.rep  = 1'b1;
            end
        endcase
        return f;
    endfunction

    assign byte_in  = i_byte.byte_in;
    assign in_fire  = i_byte.valid && i_byte.ready;
    assign out_fire = o_cp.valid && o_cp.ready;

    assign i_byte.ready = (r_cnt == '0) ||
                          ((r_cnt == utf8d_pkg::CNT_W'(1)) && o_cp.ready);

    assign o_cp.valid       = (r_cnt != '0);
    assign o_cp.last        = (r_cnt == utf8d_pkg::CNT_W'(1));
    assign o_cp.code_point  = o_cp.last ? r_cp : utf8d_pkg::REPL_CP;
    assign o_cp.replaced    = o_cp.last ? r_rep : 1'b1;
    assign o_cp.end_of_text = o_cp.last ? r_eot : 1'b0;

    assign is_cont  = (byte_in[7:6] == 2'b10);
    assign cp_cat   = {r_partial[utf8d_pkg::CP_W-7:0], byte_in[5:0]};
    assign held_inc = {1'b0, r_held} + utf8d_pkg::LEN_W'(1);
    assign seq_done = (held_inc + utf8d_pkg::LEN_W'(1)) >= r_seq_len;
    assign seq_bad  = ((r_seq_len == utf8d_pkg::LEN_TWO)   && (cp_cat < utf8d_pkg::MIN_LEN2)) ||
                      ((r_seq_len == utf8d_pkg::LEN_THREE) && (cp_cat < utf8d_pkg::MIN_LEN3)) ||
                      ((r_seq_len == utf8d_pkg::LEN_FOUR)  && (cp_cat < utf8d_pkg::MIN_LEN4)) ||
                      (cp_cat > utf8d_pkg::CP_MAX) ||
                      ((cp_cat >= utf8d_pkg::SURR_LO) && (cp_cat <= utf8d_pkg::SURR_HI));
    assign held_cap = (r_held > 2'd2) ? 2'd2 : r_held;
    assign base_cnt = utf8d_pkg::CNT_W'(1) + {1'b0, held_cap};
    assign fresh    = decode_fresh(byte_in);

    always_comb begin
        n_seq_len = r_seq_len;
        n_held    = r_held;
        n_partial = r_partial;
        n_cnt     = '0;
        n_cp      = utf8d_pkg::REPL_CP;
        n_rep     = 1'b1;
        n_eot     = 1'b0;
        if (r_seq_len == utf8d_pkg::LEN_IDLE) begin
            n_cnt = fresh.emit ? utf8d_pkg::CNT_W'(1) : '0;
            n_cp  = fresh.cp;
            n_rep = fresh.rep;
            n_eot = fresh.eot;
            if (fresh.start) begin
                n_seq_len = fresh.len;
                n_held    = '0;
                n_partial = fresh.part;
            end
        end else if (is_cont) begin
            if (seq_done) begin
                if (seq_bad) begin
                    n_cnt = r_seq_len;
                end else begin
                    n_cnt = utf8d_pkg::CNT_W'(1);
                    n_cp  = cp_cat;
                    n_rep = 1'b0;
                end
                n_seq_len = utf8d_pkg::LEN_IDLE;
                n_held    = '0;
                n_partial = '0;
            end else begin
                n_partial = cp_cat;
                n_held    = held_inc[utf8d_pkg::HELD_W-1:0];
            end
        end else begin
            // drop the broken sequence, then take this byte afresh
            n_seq_len = utf8d_pkg::LEN_IDLE;
            n_held    = '0;
            n_partial = '0;
            if (fresh.emit) begin
                n_cnt = base_cnt + utf8d_pkg::CNT_W'(1);
                n_cp  = fresh.cp;
                n_rep = fresh.rep;
                n_eot = fresh.eot;
            end else begin
                n_cnt = base_cnt;
            end
            if (fresh.start) begin
                n_seq_len = fresh.len;
                n_partial = fresh.part;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= utf8d_pkg::LEN_IDLE;
            r_held    <= '0;
            r_partial <= '0;
            r_cnt     <= '0;
        end else if (in_fire) begin
            r_seq_len <= n_seq_len;
            r_held    <= n_held;
            r_partial <= n_partial;
            r_cnt     <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - utf8d_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cp  <= n_cp;
            r_rep <= n_rep;
            r_eot <= n_eot;
        end
    end

endmodule

/* src/utf8d_checker.sv */
// Port-level checks for the UTF-8 stream decoder, bound into utf8_stream_decoder.
module utf8d_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [utf8d_pkg::CP_W-1:0]    i_code_point,
    input logic                          i_replaced,
    input logic                          i_end_of_text,
    input logic                          i_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point) &&
            $stable(i_replaced) && $stable(i_end_of_text) && $stable(i_last))
        else $error("stalled result changed");

    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_replaced |-> i_code_point == utf8d_pkg::REPL_CP &&
            !i_end_of_text)
        else $error("replaced result without U+FFFD");

    a_eot_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_of_text |-> i_code_point == '0 && i_last && !i_replaced)
        else $error("malformed end-of-text result");

    a_run_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_replaced && i_code_point == utf8d_pkg::REPL_CP)
        else $error("non-final result is not a replacement");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_cp.valid),
    .i_out_ready   (o_cp.ready),
    .i_code_point  (o_cp.code_point),
    .i_replaced    (o_cp.replaced),
    .i_end_of_text (o_cp.end_of_text),
    .i_last        (o_cp.last)
);
